>>> rtl/core/tbcl_pkg.sv
// ----------------------------------------------------------------------------
// tbcl_pkg
// shared types and constants of the tagged block chain length finder
// ----------------------------------------------------------------------------
package tbcl_pkg;

  localparam int unsigned LEN_W      = 40;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;

  // register index taken from paddr[3]
  localparam logic REG_MAX_FILE_SIZE = 1'b0;

  localparam logic [4:0] HDR_NARROW  = 5'd20;
  localparam logic [4:0] HDR_WIDE    = 5'd24;
  localparam int unsigned CHAIN_START = 12;

  localparam logic [7:0] CH_NARROW = 8'h5f;  // '_'
  localparam logic [7:0] CH_WIDE   = 8'h2d;  // '-'
  localparam logic [7:0] CH_LITTLE = 8'h76;  // 'v'

  typedef enum logic [1:0] {
    ST_END      = 2'd0,
    ST_BAD_SIG  = 2'd1,
    ST_EARLY    = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_e;

  typedef struct packed {
    logic             big_endian;
    logic             wide_pointers;
    logic [LEN_W-1:0] file_length;
    status_e          status;
  } res_t;

  // seven byte file signature
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h42;
      3'd1:    b = 8'h4c;
      3'd2:    b = 8'h45;
      3'd3:    b = 8'h4e;
      3'd4:    b = 8'h44;
      3'd5:    b = 8'h45;
      3'd6:    b = 8'h52;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // code of the end block
  function automatic logic [7:0] end_code(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h45;
      2'd1:    b = 8'h4e;
      2'd2:    b = 8'h44;
      2'd3:    b = 8'h42;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/tbcl_parser.sv
// ----------------------------------------------------------------------------
// tbcl_parser
// per-byte signature check and block chain walk, one byte per cycle
// ----------------------------------------------------------------------------
module tbcl_parser import tbcl_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [7:0]       data_i,
  input  logic             first_i,
  input  logic             last_i,
  input  logic [LEN_W-1:0] max_size_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  localparam int unsigned CmpW = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SIG,
    PH_HDR,
    PH_PAY
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [OFFSET_BITS-1:0] ofs_q, ofs_d;
  logic [OFFSET_BITS-1:0] nbs_q, nbs_d;
  logic [OFFSET_BITS-1:0] hdr_end_q, hdr_end_d;
  logic [4:0]             idx_q, idx_d;
  logic [3:0]             cm_q, cm_d;
  logic [31:0]            acc_q, acc_d;
  logic                   wide_q, wide_d;
  logic                   be_q, be_d;

  logic                   hit;
  status_e                st;
  logic [OFFSET_BITS-1:0] cur_ofs;
  logic [OFFSET_BITS:0]   ofs_inc;
  logic [4:0]             hdr_len;

  always_comb begin
    phase_d   = phase_q;
    ofs_d     = ofs_q;
    nbs_d     = nbs_q;
    hdr_end_d = hdr_end_q;
    idx_d     = idx_q;
    cm_d      = cm_q;
    acc_d     = acc_q;
    wide_d    = wide_q;
    be_d      = be_q;
    hit       = 1'b0;
    st        = ST_END;
    cur_ofs   = ofs_q;
    ofs_inc   = {1'b0, ofs_q} + 1'b1;
    hdr_len   = wide_q ? HDR_WIDE : HDR_NARROW;

    if (valid_i && (first_i || phase_q != PH_IDLE)) begin
      if (first_i) begin
        phase_d = PH_SIG;
        ofs_d   = '0;
        nbs_d   = OFFSET_BITS'(CHAIN_START);
        idx_d   = '0;
        cm_d    = '0;
        acc_d   = '0;
        wide_d  = 1'b0;
        be_d    = 1'b0;
        hdr_len = HDR_NARROW;
      end
      cur_ofs = ofs_d;
      ofs_inc = {1'b0, cur_ofs} + 1'b1;

      case (phase_d)
        PH_SIG: begin
          if (cur_ofs < OFFSET_BITS'(7)) begin
            if (data_i != sig_byte(cur_ofs[2:0])) begin
              hit = 1'b1;
              st  = ST_BAD_SIG;
            end
          end else if (cur_ofs == OFFSET_BITS'(7)) begin
            if (data_i == CH_NARROW) begin
              wide_d = 1'b0;
            end else if (data_i == CH_WIDE) begin
              wide_d = 1'b1;
            end else begin
              hit = 1'b1;
              st  = ST_BAD_SIG;
            end
          end else if (cur_ofs == OFFSET_BITS'(8)) begin
            be_d = (data_i != CH_LITTLE);
          end
        end
        PH_HDR: begin
          // block end without payload, ready before the length completes
          if (idx_d == 5'd0) begin
            hdr_end_d = nbs_d + OFFSET_BITS'(hdr_len);
          end
          if (idx_d < 5'd4) begin
            if (data_i == end_code(idx_d[1:0])) begin
              cm_d[idx_d[1:0]] = 1'b1;
            end
          end else if (idx_d < 5'd8) begin
            if (be_d) begin
              acc_d = {acc_d[23:0], data_i};
            end else begin
              acc_d = acc_d | (32'(data_i) << {idx_d[1:0], 3'b000});
            end
          end
          if (idx_d == 5'd7) begin
            if (cm_d == 4'hf) begin
              nbs_d = hdr_end_q;
            end else begin
              nbs_d = hdr_end_q + OFFSET_BITS'(acc_d);
              if (CmpW'(nbs_d) > CmpW'(max_size_i)) begin
                hit = 1'b1;
                st  = ST_OVERSIZE;
              end
            end
          end
          if (!hit && (({1'b0, idx_d} + 6'd1) >= {1'b0, hdr_len})) begin
            if (cm_d == 4'hf) begin
              hit = 1'b1;
              st  = ST_END;
            end else begin
              phase_d = PH_PAY;
            end
          end
          idx_d = idx_d + 5'd1;
        end
        default: ;
      endcase

      if (!hit) begin
        ofs_d = ofs_inc[OFFSET_BITS-1:0];
        if ((phase_d == PH_SIG || phase_d == PH_PAY) && ofs_d == nbs_d) begin
          phase_d = PH_HDR;
          idx_d   = '0;
          cm_d    = '0;
          acc_d   = '0;
        end
        if (last_i) begin
          hit = 1'b1;
          st  = ST_EARLY;
        end
      end
      if (hit) begin
        phase_d = PH_IDLE;
      end
    end
  end

  assign res_valid_o         = hit;
  assign res_o.status        = st;
  assign res_o.file_length   = (st == ST_END) ? LEN_W'(nbs_d) : LEN_W'(ofs_inc);
  assign res_o.wide_pointers = wide_d;
  assign res_o.big_endian    = be_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      ofs_q     <= '0;
      nbs_q     <= OFFSET_BITS'(CHAIN_START);
      hdr_end_q <= '0;
      idx_q     <= '0;
      cm_q      <= '0;
      acc_q     <= '0;
      wide_q    <= 1'b0;
      be_q      <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ofs_q     <= ofs_d;
      nbs_q     <= nbs_d;
      hdr_end_q <= hdr_end_d;
      idx_q     <= idx_d;
      cm_q      <= cm_d;
      acc_q     <= acc_d;
      wide_q    <= wide_d;
      be_q      <= be_d;
    end
  end

endmodule

>>> rtl/core/tbcl_out_buf.sv
// ----------------------------------------------------------------------------
// tbcl_out_buf
// two-entry result buffer between the parser and the output stream
// ----------------------------------------------------------------------------
module tbcl_out_buf import tbcl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  res_t wr_data_i,
  output logic full_o,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output res_t rd_data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       rd;

  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_valid_o = (cnt_q != 2'd0);
  assign full_o     = (cnt_q == 2'd2);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd};
    end
  end

endmodule

>>> rtl/core/tagged_block_chain_length_finder.sv
// ----------------------------------------------------------------------------
// tagged_block_chain_length_finder
// walks the block chain of a candidate file byte by byte and reports its length
// ----------------------------------------------------------------------------
//
//   channel   direction  payload
//   s_axis    in         tdata: data_byte, tuser: first_byte, tlast: last_byte
//   m_axis    out        tdata: file_length, tuser: status, wide, big_endian
//   apb       in/out     reg 0 at 0x0: max_file_size (40 bits)
//
// one byte is taken every cycle while a buffer entry is free; each byte costs a compare,
// a field capture and one offset-wide add in the parser
// the result of the byte that ends the walk is registered in the result buffer before m_axis
// the two-entry result buffer keeps taking bytes while one result waits;
// s_axis_tready drops only when both entries are occupied
// reset: max_file_size all ones, parser idle until a byte with first_byte
//
module tagged_block_chain_length_finder import tbcl_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // byte stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tuser,   // [0] first_byte
  input  logic                  s_axis_tlast,
  // results out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [LEN_W-1:0]      m_axis_tdata,   // [39:0] file_length
  output logic [3:0]            m_axis_tuser,   // [1:0] status, [2] wide_pointers,
                                                // [3] big_endian
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic             max_we;
  logic [LEN_W-1:0] max_size_q;
  logic             buf_full;
  logic             in_acc;
  logic             res_valid;
  res_t             res;
  res_t             out_res;

  // configuration register, 8-byte stride
  assign pready = 1'b1;
  assign max_we = psel && penable && pwrite && (paddr[3] == REG_MAX_FILE_SIZE);
  assign prdata = (paddr[3] == REG_MAX_FILE_SIZE) ? CFG_DATA_W'(max_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= '1;
    end else if (max_we) begin
      max_size_q <= pwdata[LEN_W-1:0];
    end
  end

  assign s_axis_tready = !buf_full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  tbcl_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_acc),
    .data_i     (s_axis_tdata),
    .first_i    (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .max_size_i (max_size_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result register with one skid entry
  tbcl_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res),
    .full_o    (buf_full),
    .rd_valid_o(m_axis_tvalid),
    .rd_ready_i(m_axis_tready),
    .rd_data_o (out_res)
  );

  assign m_axis_tdata = out_res.file_length;
  assign m_axis_tuser = {out_res.big_endian, out_res.wide_pointers, out_res.status};

endmodule

>>> rtl/core/tbcl_checker.sv
// ----------------------------------------------------------------------------
// tbcl_checker
// port-level checks of the length finder, bound to the top level
// ----------------------------------------------------------------------------
module tbcl_checker import tbcl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             s_ready_i,
  input  logic [7:0]       s_data_i,
  input  logic             s_user_i,
  input  logic             m_valid_i,
  input  logic             m_ready_i,
  input  logic [LEN_W-1:0] m_data_i,
  input  logic [3:0]       m_user_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i) && $stable(m_user_i))
    else $error("result changed while stalled");

  // a wrong first signature byte gives a result at once
  a_bad_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_i && s_ready_i && s_user_i && (s_data_i != sig_byte(3'd0)) |=> m_valid_i)
    else $error("no result after bad first byte");

  // signature failures happen within the first eight bytes
  a_bad_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && (m_user_i[1:0] == ST_BAD_SIG) |->
      (m_data_i >= LEN_W'(1)) && (m_data_i <= LEN_W'(8)))
    else $error("bad signature count out of range");

  // signature failures come before the layout bytes take effect
  a_bad_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && (m_user_i[1:0] == ST_BAD_SIG) |-> (m_user_i[3:2] == 2'b00))
    else $error("layout flags set on bad signature");

endmodule

bind tagged_block_chain_length_finder tbcl_checker u_tbcl_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_valid_i(s_axis_tvalid),
  .s_ready_i(s_axis_tready),
  .s_data_i (s_axis_tdata),
  .s_user_i (s_axis_tuser),
  .m_valid_i(m_axis_tvalid),
  .m_ready_i(m_axis_tready),
  .m_data_i (m_axis_tdata),
  .m_user_i (m_axis_tuser)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tagged block chain length finder: byte streams
// of well-formed, truncated, corrupted and abandoned files go in under random
// flow control, and every report is compared against the directed table or an in-bench chain walker
// ----------------------------------------------------------------------------
module tb;
  import tbcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned STALL_CYCLES = 60;

  // file signature, byte 0 in the low bits
  localparam logic [55:0] FILE_SIG = 56'h52_45_44_4e_45_4c_42;
  // code of the closing block, byte 0 in the low bits
  localparam logic [31:0] END_TAG = 32'h42_44_4e_45;

  // parse phases of the walker
  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_SIG,
    WALK_HDR,
    WALK_PAY
  } walk_e;

  // one row of the directed table; rep is used only where typed is set
  typedef struct {
    logic [7:0] b;
    logic       is_first;
    logic       is_last;
    logic       typed;
    res_t       rep;
  } row_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [LEN_W-1:0] m_axis_tdata;
  logic [3:0]       m_axis_tuser;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // typed expectation travelling with the byte currently offered
  logic cur_typed = 1'b0;
  res_t cur_rep   = '0;

  // flow control knobs
  logic calm        = 1'b0;  // no idling on either side
  logic pressure_on = 1'b0;  // ask the receiver for one long hold-off

  // walker state, mirrors the block
  walk_e       walk_phase = WALK_IDLE;
  logic [39:0] walk_ofs   = '0;
  logic [39:0] walk_next  = 40'(CHAIN_START);
  logic [4:0]  walk_hidx  = '0;
  logic [3:0]  walk_code  = '0;
  logic [31:0] walk_len   = '0;
  logic        walk_wide  = 1'b0;
  logic        walk_big   = 1'b0;
  logic [39:0] size_limit = '1;

  res_t        pending_reports [$];
  logic [7:0]  fbuf [$];
  row_t        plan [$];
  int          faults       = 0;
  int          reports_seen = 0;
  int          bytes_walked = 0;
  int          status_tally [4] = '{0, 0, 0, 0};
  int unsigned cycles       = 0;
  logic [39:0] mid_limit;

  tagged_block_chain_length_finder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tuser (s_axis_tuser),   // [0] first_byte
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [39:0] file_length
    .m_axis_tuser (m_axis_tuser),   // [1:0] status, [2] wide_pointers, [3] big_endian
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still awaited", cycles,
               pending_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  // walks one accepted byte through the chain and tells whether it ends the walk
  task automatic walk_byte(input logic [7:0] b, input logic first, input logic last,
                           output logic made, output res_t rep);
    logic [39:0] at;
    logic [4:0]  hsz;
    logic [4:0]  idx;
    logic        hit;
    status_e     st;
    made = 1'b0;
    rep  = '0;
    hit  = 1'b0;
    st   = ST_END;
    // first_byte restarts even in the middle of a walk
    if (first) begin
      walk_ofs   = '0;
      walk_next  = 40'(CHAIN_START);
      walk_hidx  = '0;
      walk_code  = '0;
      walk_len   = '0;
      walk_wide  = 1'b0;
      walk_big   = 1'b0;
      walk_phase = WALK_SIG;
    end
    // bytes seen while idle are dropped without a report
    if (walk_phase != WALK_IDLE) begin
      bytes_walked++;
      at = walk_ofs;
      case (walk_phase)
        WALK_SIG: begin
          if (at < 7) begin
            if (b != FILE_SIG[8*at[2:0] +: 8]) begin
              hit = 1'b1;
              st  = ST_BAD_SIG;
            end
          end else if (at == 7) begin
            if (b == CH_NARROW) walk_wide = 1'b0;
            else if (b == CH_WIDE) walk_wide = 1'b1;
            else begin
              hit = 1'b1;
              st  = ST_BAD_SIG;
            end
          end else if (at == 8) begin
            walk_big = (b != CH_LITTLE);
          end
          // bytes 9 to 11 pass unchecked
        end
        WALK_HDR: begin
          hsz = walk_wide ? HDR_WIDE : HDR_NARROW;
          idx = walk_hidx;
          if (idx < 4) begin
            if (b == END_TAG[8*idx[1:0] +: 8]) walk_code[idx[1:0]] = 1'b1;
          end else if (idx < 8) begin
            if (walk_big) walk_len = {walk_len[23:0], b};
            else walk_len[8*idx[1:0] +: 8] = b;
          end
          // length field complete: next block start, limit only for non-closing blocks
          if (idx == 7) begin
            if (&walk_code) begin
              walk_next = walk_next + 40'(hsz);
            end else begin
              walk_next = walk_next + 40'(hsz) + 40'(walk_len);
              if (walk_next > size_limit) begin
                hit = 1'b1;
                st  = ST_OVERSIZE;
              end
            end
          end
          // closing block reports on its last header byte
          if (!hit && 6'(idx) + 6'd1 >= 6'(hsz)) begin
            if (&walk_code) begin
              hit = 1'b1;
              st  = ST_END;
            end else begin
              walk_phase = WALK_PAY;
            end
          end
          walk_hidx = idx + 5'd1;
        end
        default: ;
      endcase
      if (!hit) begin
        walk_ofs = at + 40'd1;
        if ((walk_phase == WALK_SIG || walk_phase == WALK_PAY) && walk_ofs == walk_next) begin
          walk_phase = WALK_HDR;
          walk_hidx  = '0;
          walk_code  = '0;
          walk_len   = '0;
        end
        // early end only when nothing else was found on this byte
        if (last) begin
          hit = 1'b1;
          st  = ST_EARLY;
        end
      end
      if (hit) begin
        made              = 1'b1;
        rep.status        = st;
        rep.file_length   = (st == ST_END) ? walk_next : at + 40'd1;
        rep.wide_pointers = walk_wide;
        rep.big_endian    = walk_big;
        walk_phase        = WALK_IDLE;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [39:0] want,
                             input logic [39:0] got);
    if (want !== got) begin
      faults++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // input side feeds the walker, output side is compared against the oldest report
  always @(posedge clk_i) begin : monitor
    logic made;
    res_t rep;
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          faults++;
          $display("%0t ns: report with none awaited, expected nothing, actual status %0d length %0h",
                   $time, m_axis_tuser[1:0], m_axis_tdata);
        end else begin
          want = pending_reports.pop_front();
          status_tally[want.status]++;
          check_field("status", 40'(want.status), 40'(m_axis_tuser[1:0]));
          check_field("file_length", want.file_length, m_axis_tdata);
          check_field("wide_pointers", 40'(want.wide_pointers), 40'(m_axis_tuser[2]));
          check_field("big_endian", 40'(want.big_endian), 40'(m_axis_tuser[3]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        walk_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, made, rep);
        // typed rows of the directed table stand for themselves
        if (cur_typed) pending_reports.push_back(cur_rep);
        else if (made) pending_reports.push_back(rep);
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk_i) begin : receiver
    int  stall_left;
    bit  stall_used;
    if (pressure_on && !stall_used) begin
      stall_left = STALL_CYCLES;
      stall_used = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // offers one byte and returns at the edge where it is taken
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic typed, input res_t rep);
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    cur_typed     <= typed;
    cur_rep       <= rep;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stream goes quiet and waits until every report is in
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write with a setup and an access phase, only while the parser is idle
  task automatic set_size_limit(input logic [39:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_FILE_SIZE, 3'b000};
    pwdata  <= {24'($urandom), v};   // upper bits are not part of the register
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_limit = v;
  endtask

  // builds a chain of 0..2 ordinary blocks and a closing block into fbuf;
  // a huge payload length leaves the file open-ended after a few bytes
  task automatic build_file(output logic open_end);
    logic        wide;
    logic        big;
    logic [7:0]  mode;
    logic [4:0]  hsz;
    logic [31:0] plen;
    int          nblk;
    int          skip;
    fbuf.delete();
    open_end = 1'b0;
    for (int k = 0; k < 7; k++) fbuf.push_back(FILE_SIG[8*k +: 8]);
    wide = 1'($urandom_range(1));
    fbuf.push_back(wide ? CH_WIDE : CH_NARROW);
    mode = $urandom_range(1) ? CH_LITTLE : 8'($urandom);
    big  = (mode != CH_LITTLE);
    fbuf.push_back(mode);
    repeat (3) fbuf.push_back(8'($urandom));
    hsz  = wide ? HDR_WIDE : HDR_NARROW;
    nblk = $urandom_range(2);
    for (int blk = 0; blk < nblk && !open_end; blk++) begin
      // code close to the closing one but never equal
      skip = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
        if (k == skip) fbuf.push_back(END_TAG[8*k +: 8] ^ 8'($urandom_range(1, 255)));
        else fbuf.push_back($urandom_range(1) ? END_TAG[8*k +: 8] : 8'($urandom));
      end
      plen = ($urandom_range(9) == 0) ? $urandom : $urandom_range(16);
      for (int k = 0; k < 4; k++) fbuf.push_back(big ? plen[8*(3-k) +: 8] : plen[8*k +: 8]);
      for (int k = 8; k < hsz; k++) fbuf.push_back(8'($urandom));
      if (plen > 16) begin
        open_end = 1'b1;
        repeat ($urandom_range(1, 6)) fbuf.push_back(8'($urandom));
      end else begin
        repeat (plen) fbuf.push_back(8'($urandom));
      end
    end
    if (!open_end) begin
      for (int k = 0; k < 4; k++) fbuf.push_back(END_TAG[8*k +: 8]);
      for (int k = 4; k < hsz; k++) fbuf.push_back(8'($urandom));
    end
  endtask

  // one random sequence of bytes
  task automatic emit_sequence(output int n);
    int   kind;
    int   cut;
    int   pos;
    int   last_at;
    logic open_end;
    last_at = -1;
    n       = 0;
    kind    = $urandom_range(99);
    if (kind >= 93) begin
      // loose bytes without first_byte, mostly dropped by an idle parser
      fbuf.delete();
      repeat ($urandom_range(1, 4)) fbuf.push_back(8'($urandom));
      for (int i = 0; i < fbuf.size(); i++)
        send_byte(fbuf[i], 1'b0, (i == fbuf.size() - 1) && $urandom_range(1), 1'b0, '0);
    end else begin
      build_file(open_end);
      if (kind < 50) begin
        // well-formed or open-ended; last_byte always ends an open-ended file, sometimes a closing one
        if (open_end || $urandom_range(9) == 0) last_at = fbuf.size() - 1;
      end else if (kind < 70) begin
        // stream ends early at a random point
        cut = $urandom_range(1, fbuf.size() - 1);
        while (fbuf.size() > cut) void'(fbuf.pop_back());
        last_at = cut - 1;
      end else if (kind < 85) begin
        // one damaged byte in the signature or the layout byte
        pos = $urandom_range(7);
        fbuf[pos] = fbuf[pos] ^ 8'($urandom_range(1, 255));
        cut = pos + 1 + $urandom_range(3);
        while (fbuf.size() > cut) void'(fbuf.pop_back());
        if ($urandom_range(1)) last_at = cut - 1;
      end else begin
        // abandoned halfway, the next first_byte restarts
        cut = $urandom_range(1, fbuf.size() - 1);
        while (fbuf.size() > cut) void'(fbuf.pop_back());
      end
      for (int i = 0; i < fbuf.size(); i++)
        send_byte(fbuf[i], i == 0, i == last_at, 1'b0, '0);
      n = fbuf.size();
    end
  endtask

  // random sequences up to the quota, then one failing first byte leaves the
  // parser idle before the stream drains
  task automatic run_phase(input int quota);
    int sent;
    int n;
    sent = 0;
    while (sent < quota) begin
      emit_sequence(n);
      sent += n;
    end
    send_byte(8'h00, 1'b1, 1'b0, 1'b0, '0);
    drain();
  endtask

  function automatic row_t row(input logic [7:0] b, input logic first, input logic last,
                               input logic typed, input status_e st,
                               input logic [39:0] len, input logic wide,
                               input logic big);
    row_t r;
    r.b                 = b;
    r.is_first          = first;
    r.is_last           = last;
    r.typed             = typed;
    r.rep.status        = st;
    r.rep.file_length   = len;
    r.rep.wide_pointers = wide;
    r.rep.big_endian    = big;
    return r;
  endfunction

  initial begin
    // bytes before any first_byte are dropped, even with last_byte
    plan.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, ST_END, 40'd0, 1'b0, 1'b0));
    plan.push_back(row(8'hff, 1'b0, 1'b1, 1'b0, ST_END, 40'd0, 1'b0, 1'b0));
    // wrong first byte fails at once
    plan.push_back(row(8'h58, 1'b1, 1'b0, 1'b1, ST_BAD_SIG, 40'd1, 1'b0, 1'b0));
    // one good byte then end of stream
    plan.push_back(row(8'h42, 1'b1, 1'b1, 1'b1, ST_EARLY, 40'd1, 1'b0, 1'b0));
    // restart in the middle of the signature
    plan.push_back(row(8'h42, 1'b1, 1'b0, 1'b0, ST_END, 40'd0, 1'b0, 1'b0));
    plan.push_back(row(8'h4c, 1'b0, 1'b0, 1'b0, ST_END, 40'd0, 1'b0, 1'b0));
    for (int k = 0; k < 7; k++)
      plan.push_back(row(FILE_SIG[8*k +: 8], k == 0, 1'b0, 1'b0, ST_END, 40'd0, 1'b0, 1'b0));
    // layout byte neither narrow nor wide
    plan.push_back(row(8'h3d, 1'b0, 1'b0, 1'b1, ST_BAD_SIG, 40'd8, 1'b0, 1'b0));
    // wide layout, big-endian, stream ends on byte 9
    for (int k = 0; k < 7; k++)
      plan.push_back(row(FILE_SIG[8*k +: 8], k == 0, 1'b0, 1'b0, ST_END, 40'd0, 1'b0, 1'b0));
    plan.push_back(row(CH_WIDE, 1'b0, 1'b0, 1'b0, ST_END, 40'd0, 1'b0, 1'b0));
    plan.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, ST_END, 40'd0, 1'b0, 1'b0));
    plan.push_back(row(8'hff, 1'b0, 1'b1, 1'b1, ST_EARLY, 40'd10, 1'b1, 1'b1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset limit
    for (int i = 0; i < plan.size(); i++)
      send_byte(plan[i].b, plan[i].is_first, plan[i].is_last, plan[i].typed, plan[i].rep);
    send_byte(8'h00, 1'b0, 1'b0, 1'b0, '0);  // clears the typed flag, dropped while idle
    drain();

    // random files at the reset limit
    run_phase(70);

    // zero limit: every ordinary block is oversize, a lone closing block still passes
    set_size_limit(40'd0);
    run_phase(30);

    // limit right at the first block boundary of short payloads, no idling
    set_size_limit(40'd44);
    calm <= 1'b1;
    run_phase(50);
    calm <= 1'b0;

    // mid-range limit, long output hold-off while one-byte failures pile up
    mid_limit = 40'($urandom_range(60, 400));
    set_size_limit(mid_limit);
    pressure_on <= 1'b1;
    repeat (16) send_byte(8'($urandom_range(0, 8'h41)), 1'b1, 1'b0, 1'b0, '0);
    pressure_on <= 1'b0;
    run_phase(45);

    // full 40-bit limit written explicitly
    set_size_limit('1);
    run_phase(50);

    $display("walked %0d bytes, %0d reports: %0d closed, %0d bad signature, %0d early end, %0d oversize",
             bytes_walked, reports_seen, status_tally[ST_END], status_tally[ST_BAD_SIG],
             status_tally[ST_EARLY], status_tally[ST_OVERSIZE]);
    $display("size limits: reset, 0, 44, %0d, all ones; one %0d-cycle output hold-off",
             mid_limit, STALL_CYCLES);
    if (faults == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
